FILE: src/ipdd_pkg.sv
// Shared types and constants for the IPD frame deframer.
// Holds the beat classification record, status codes and header table.
// No dependencies.
`default_nettype none

package ipdd_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int MAX_LINK_DEF    = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam int HDR_LEN   = 7;
  localparam int HIDX_W    = 10;
  localparam int TMO_W     = 16;
  localparam int HLIM_W    = 11;
  localparam int CFG_W     = 16;
  localparam int FLEN_W    = 16;
  localparam int LID_W     = 3;
  localparam int TDATA_W   = 32;

  localparam logic [HIDX_W-1:0] ID_POS    = HIDX_W'(7);
  localparam logic [HIDX_W-1:0] COMMA_POS = HIDX_W'(8);
  localparam logic [HLIM_W-1:0] HLIM_MAX  = HLIM_W'(1024);
  localparam logic [HIDX_W-1:0] HTHR_MAX  = HIDX_W'(1023);
  localparam logic [HIDX_W-1:0] HTHR_RST  = HIDX_W'(63);

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [7:0] HDR_TAB [HDR_LEN] = '{8'd13, 8'd10, 8'd43, 8'd73, 8'd80, 8'd68, 8'd44};

  typedef enum logic [0:0] {
    REG_TIMEOUT   = 1'b0,
    REG_HDR_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_HDR_LONG = 3'd4,
    ST_LEN_OVF  = 3'd5,
    ST_TIMEOUT  = 3'd6
  } status_e;

  typedef struct packed {
    logic               tick;
    logic [7:0]         data;
    logic               is_cr;
    logic               is_comma;
    logic               is_colon;
    logic               is_digit;
    logic [3:0]         digit;
    logic               id_ok;
    logic [HDR_LEN-1:0] hdr_match;
  } beat_cls_t;

endpackage

`default_nettype wire

FILE: src/ipdd_front.sv
// Front end of the IPD frame deframer: takes input beats and classifies them.
// Depends on ipdd_pkg; feeds ipdd_queue.
`default_nettype none

module ipdd_front #(
  parameter int MAX_LINK = ipdd_pkg::MAX_LINK_DEF
) (
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,
  input  wire logic [0:0]          s_axis_tuser,
  input  wire logic                q_full,
  output logic                     push,
  output ipdd_pkg::beat_cls_t      push_item
);
  import ipdd_pkg::*;

  logic [7:0] rel;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;
  assign rel           = s_axis_tdata - CH_ZERO;

  always_comb begin
    push_item          = '0;
    push_item.tick     = s_axis_tuser[0];
    push_item.data     = s_axis_tdata;
    push_item.is_cr    = (s_axis_tdata == CH_CR);
    push_item.is_comma = (s_axis_tdata == CH_COMMA);
    push_item.is_colon = (s_axis_tdata == CH_COLON);
    push_item.is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    push_item.digit    = rel[3:0];
    push_item.id_ok    = (s_axis_tdata >= CH_ZERO) && (rel <= 8'(MAX_LINK));
    for (int k = 0; k < HDR_LEN; k++) begin
      push_item.hdr_match[k] = (s_axis_tdata == HDR_TAB[k]);
    end
  end

endmodule

`default_nettype wire

FILE: src/ipdd_queue.sv
// Short queue of classified beats between the front and back ends.
// Depends on ipdd_pkg.
`default_nettype none

module ipdd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ipdd_pkg::beat_cls_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output ipdd_pkg::beat_cls_t      pop_item
);
  import ipdd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  beat_cls_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ipdd_back.sv
// Back end of the IPD frame deframer: header parser, payload counter, timer,
// configuration registers and the output register. Depends on ipdd_pkg.
`default_nettype none

module ipdd_back #(
  parameter int LENGTH_BITS = ipdd_pkg::LENGTH_BITS_DEF,
  parameter int MAX_LINK    = ipdd_pkg::MAX_LINK_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_addr,
  input  wire logic [ipdd_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          q_not_empty,
  input  wire ipdd_pkg::beat_cls_t           q_item,
  output logic                               pop,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ipdd_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic [2:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);
  import ipdd_pkg::*;

  localparam int LB    = LENGTH_BITS;
  localparam int FID_W = (MAX_LINK > 0) ? $clog2(MAX_LINK + 1) : 1;

  logic [TMO_W-1:0]  timeout_ticks;
  logic [HIDX_W-1:0] header_thr;

  logic              in_payload, in_payload_next;
  logic [HIDX_W-1:0] header_index, header_index_next;
  logic [FID_W-1:0]  frame_id, frame_id_next;
  logic [LB-1:0]     length_accum, length_accum_next;
  logic [LB-1:0]     bytes_left, bytes_left_next;
  logic [TMO_W-1:0]  idle_ticks, idle_ticks_next;

  logic [TMO_W-1:0]  idle_inc;
  logic [LB+3:0]     len_grown;
  logic [HLIM_W-1:0] hlim_wr;

  logic              res_valid;
  status_e           res_status;
  logic [7:0]        res_byte;
  logic              res_last;
  logic              do_fail;
  logic              do_clear;
  logic              advance;
  logic              reexam;
  status_e           fail_code;

  logic [LB+FLEN_W-1:0]   len_ext;
  logic [FID_W+LID_W-1:0] fid_ext;

  assign pop       = q_not_empty && (!m_axis_tvalid || m_axis_tready);
  assign idle_inc  = (idle_ticks != '1) ? idle_ticks + 1'b1 : idle_ticks;
  assign len_grown = ({4'b0, length_accum} << 3) + ({4'b0, length_accum} << 1)
                   + (LB+4)'(q_item.digit);
  assign hlim_wr   = cfg_data[HLIM_W-1:0];
  assign len_ext   = {{FLEN_W{1'b0}}, length_accum};
  assign fid_ext   = {{LID_W{1'b0}}, frame_id};

  always_comb begin
    in_payload_next   = in_payload;
    header_index_next = header_index;
    frame_id_next     = frame_id;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    idle_ticks_next   = idle_ticks;
    res_valid         = 1'b0;
    res_status        = ST_PAYLOAD;
    res_byte          = '0;
    res_last          = 1'b0;
    do_fail           = 1'b0;
    do_clear          = 1'b0;
    advance           = 1'b0;
    reexam            = 1'b0;
    fail_code         = ST_MISMATCH;

    if (pop) begin
      if (q_item.tick) begin
        if (timeout_ticks != '0) begin
          if (idle_inc >= timeout_ticks) begin
            do_fail   = 1'b1;
            fail_code = ST_TIMEOUT;
          end else begin
            idle_ticks_next = idle_inc;
          end
        end
      end else if (in_payload) begin
        bytes_left_next = bytes_left - 1'b1;
        res_valid       = 1'b1;
        res_byte        = q_item.data;
        if (bytes_left == LB'(1)) begin
          res_last = 1'b1;
          do_clear = 1'b1;
        end
      end else if (header_index >= header_thr) begin
        do_fail   = 1'b1;
        fail_code = ST_HDR_LONG;
        reexam    = (header_index != '0);
      end else if (header_index < HIDX_W'(HDR_LEN)) begin
        if (!q_item.hdr_match[header_index[2:0]]) begin
          do_fail   = 1'b1;
          fail_code = ST_MISMATCH;
          reexam    = (header_index != '0);
        end else begin
          advance = 1'b1;
        end
      end else if (header_index == ID_POS) begin
        if (!q_item.id_ok) begin
          do_fail   = 1'b1;
          fail_code = ST_BAD_ID;
          reexam    = 1'b1;
        end else begin
          frame_id_next = FID_W'(q_item.digit);
          advance       = 1'b1;
        end
      end else if (header_index == COMMA_POS) begin
        if (!q_item.is_comma) begin
          do_fail   = 1'b1;
          fail_code = ST_MISMATCH;
          reexam    = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end else if (q_item.is_digit) begin
        if (len_grown[LB+3:LB] != 4'b0) begin
          do_fail   = 1'b1;
          fail_code = ST_LEN_OVF;
          reexam    = 1'b1;
        end else begin
          length_accum_next = len_grown[LB-1:0];
          advance           = 1'b1;
        end
      end else if (q_item.is_colon) begin
        if (length_accum == '0) begin
          res_valid  = 1'b1;
          res_status = ST_EMPTY;
          do_clear   = 1'b1;
        end else begin
          in_payload_next   = 1'b1;
          bytes_left_next   = length_accum;
          header_index_next = '0;
          idle_ticks_next   = '0;
        end
      end else begin
        do_fail   = 1'b1;
        fail_code = ST_MISMATCH;
        reexam    = 1'b1;
      end
    end

    if (advance) begin
      header_index_next = header_index + 1'b1;
      idle_ticks_next   = '0;
    end

    if (do_fail) begin
      res_valid  = 1'b1;
      res_status = fail_code;
      do_clear   = 1'b1;
    end

    if (do_clear) begin
      in_payload_next   = 1'b0;
      header_index_next = '0;
      frame_id_next     = '0;
      length_accum_next = '0;
      bytes_left_next   = '0;
      idle_ticks_next   = '0;
      if (reexam && q_item.is_cr) begin
        header_index_next = HIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= '0;
      header_thr    <= HTHR_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_addr))
        REG_TIMEOUT: begin
          timeout_ticks <= cfg_data[TMO_W-1:0];
        end
        REG_HDR_LIMIT: begin
          if (hlim_wr == '0) begin
            header_thr <= '0;
          end else if (hlim_wr > HLIM_MAX) begin
            header_thr <= HTHR_MAX;
          end else begin
            header_thr <= HIDX_W'(hlim_wr - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      header_index  <= '0;
      frame_id      <= '0;
      length_accum  <= '0;
      bytes_left    <= '0;
      idle_ticks    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      in_payload    <= in_payload_next;
      header_index  <= header_index_next;
      frame_id      <= frame_id_next;
      length_accum  <= length_accum_next;
      bytes_left    <= bytes_left_next;
      idle_ticks    <= idle_ticks_next;
      if (res_valid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= {5'b0, len_ext[FLEN_W-1:0], fid_ext[LID_W-1:0], res_byte};
      m_axis_tuser <= res_status;
      m_axis_tlast <= res_last;
    end
  end

  a_fid_range: assert property (@(posedge clk) disable iff (rst)
    frame_id <= FID_W'(MAX_LINK))
    else $error("frame id beyond highest link");

  a_payload_idx: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_index == '0))
    else $error("header index not cleared during payload");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

FILE: src/ipd_frame_deframer.sv
// IPD frame deframer top level: front classifier, beat queue and back end.
// Depends on ipdd_pkg, ipdd_front, ipdd_queue and ipdd_back.
//
// The slave stream carries one beat per UART byte or timer tick (tuser = 1
// marks a tick). The deframer recognizes "\r\n+IPD,<id>,<len>:<payload>" and
// the master stream returns at most one beat per input beat: payload bytes
// (tlast on the final byte), an empty-frame mark, or an error code in tuser.
// The configuration port sets the tick timeout and the header length limit;
// the user must write it only while no beats are in flight; the block does not enforce this.
// A result beat passes through the beat queue and the output register on its
// way to the master side. Throughput: one beat per cycle while the receiver
// takes the output beats (m_axis_tready high or no beat held).
// A two-beat queue sits between the classifier and the back end, and the
// output register holds a beat the receiver has not taken; while the
// receiver stalls, the queue fills and s_axis_tready drops after two beats.
// Reset (synchronous, active high) clears the parser, empties the queue and
// the output register, and restores the timeout to zero (off) and the
// header limit to 64.
`default_nettype none

module ipd_frame_deframer #(
  parameter int LENGTH_BITS = ipdd_pkg::LENGTH_BITS_DEF,
  parameter int MAX_LINK    = ipdd_pkg::MAX_LINK_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_addr,
  input  wire logic [ipdd_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // rx_byte[7:0]
  input  wire logic [7:0]                  s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // payload_byte[7:0], link_id[10:8], frame_length[26:11], zero[31:27]
  output logic [ipdd_pkg::TDATA_W-1:0]     m_axis_tdata,
  // status[2:0]
  output logic [2:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import ipdd_pkg::*;

  logic      q_full;
  logic      q_push;
  beat_cls_t q_push_item;
  logic      q_pop;
  logic      q_not_empty;
  beat_cls_t q_pop_item;

  ipdd_front #(
    .MAX_LINK (MAX_LINK)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .push          (q_push),
    .push_item     (q_push_item)
  );

  ipdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_pop_item)
  );

  ipdd_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .MAX_LINK    (MAX_LINK)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .q_not_empty   (q_not_empty),
    .q_item        (q_pop_item),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
